### design/running_median_filter_macros.svh
// Assertion macros for the running median filter RTL.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef RUNNING_MEDIAN_FILTER_MACROS_SVH
`define RUNNING_MEDIAN_FILTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RMF_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("running median filter check failed");

// Next-cycle implication, disabled during reset.
`define RMF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("running median filter check failed");

`endif

### design/rmf_pkg.sv
// Shared types for the running median filter.
// No dependencies; used by rmf_median and running_median_filter.
package rmf_pkg;

    // Flow control from the top level to the result stage.
    typedef struct packed {
        logic load;   // compute stage holds an item and the result slot is free
        logic take;   // downstream takes the current result this cycle
    } rmf_stage_t;

endpackage

### design/running_median_filter.sv
// Running median filter: an accepted sample is written into the window registers,
// and the result register loads the median of that window when it is free. Takes
// one item per cycle while the result register is free. Reset (async, active low)
// clears the window, fill count, write slot and all valid flags. Depends on rmf_pkg,
// rmf_median and running_median_filter_macros.svh.
`include "running_median_filter_macros.svh"

module running_median_filter #(
    parameter int WINDOW      = 5,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          median_valid,
    input  logic                          median_stall,
    output logic signed [SAMPLE_BITS-1:0] median_value
);

    localparam int CNT_BITS = $clog2(WINDOW + 1);
    localparam int POS_BITS = $clog2(WINDOW);

    logic [WINDOW-1:0][SAMPLE_BITS-1:0] window_reg;
    logic [WINDOW-1:0][SAMPLE_BITS-1:0] window_next;
    logic [CNT_BITS-1:0]                fill_count_reg;
    logic [CNT_BITS-1:0]                fill_count_next;
    logic [POS_BITS-1:0]                write_pos_reg;
    logic [POS_BITS-1:0]                write_pos_next;
    logic                               stage_valid_reg;
    logic                               stage_valid_next;

    logic                accept;
    logic                out_free;
    rmf_pkg::rmf_stage_t stage;

    assign out_free     = !median_valid || !median_stall;
    assign sample_stall = stage_valid_reg && !out_free;
    assign accept       = sample_valid && !sample_stall;

    assign stage.load = stage_valid_reg && out_free;
    assign stage.take = median_valid && !median_stall;

    always_comb
    begin
        window_next      = window_reg;
        fill_count_next  = fill_count_reg;
        write_pos_next   = write_pos_reg;
        stage_valid_next = stage_valid_reg;
        if (out_free)
            stage_valid_next = 1'b0;
        if (accept)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                if (write_pos_reg == POS_BITS'(i))
                    window_next[i] = sample;
            end
            // advance and wrap the write slot
            if (write_pos_reg == POS_BITS'(WINDOW - 1))
                write_pos_next = '0;
            else
                write_pos_next = write_pos_reg + POS_BITS'(1);
            if (fill_count_reg != CNT_BITS'(WINDOW))
                fill_count_next = fill_count_reg + CNT_BITS'(1);
            stage_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg      <= '0;
            fill_count_reg  <= '0;
            write_pos_reg   <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            window_reg      <= window_next;
            fill_count_reg  <= fill_count_next;
            write_pos_reg   <= write_pos_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    rmf_median #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_median (
        .clk          (clk),
        .rst_n        (rst_n),
        .window       (window_reg),
        .fill_count   (fill_count_reg),
        .stage        (stage),
        .median_value (median_value),
        .median_valid (median_valid)
    );

    `RMF_ASSERT(a_fill_range, 1'b1, fill_count_reg <= CNT_BITS'(WINDOW))
    `RMF_ASSERT(a_warmup_slot, fill_count_reg < CNT_BITS'(WINDOW), CNT_BITS'(write_pos_reg) == fill_count_reg)
    `RMF_ASSERT(a_stage_has_data, stage_valid_reg, fill_count_reg != '0)
    `RMF_ASSERT_NEXT(a_accept_fills_stage, accept, stage_valid_reg)
    `RMF_ASSERT_NEXT(a_blocked_holds, stage_valid_reg && !out_free, stage_valid_reg && $stable(fill_count_reg) && $stable(write_pos_reg))

endmodule

### design/rmf_median.sv
// Median select over the sample window and the result register.
// Depends on rmf_pkg (rmf_stage_t).
module rmf_median #(
    parameter int WINDOW      = 5,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [WINDOW-1:0][SAMPLE_BITS-1:0]    window,
    input  logic [$clog2(WINDOW+1)-1:0]           fill_count,
    input  rmf_pkg::rmf_stage_t                   stage,
    output logic signed [SAMPLE_BITS-1:0]         median_value,
    output logic                                  median_valid
);

    localparam int CNT_BITS = $clog2(WINDOW + 1);
    localparam int POS_BITS = $clog2(WINDOW);

    logic [POS_BITS-1:0]    rank [WINDOW];
    logic [WINDOW-1:0]      slot_valid;
    logic [POS_BITS-1:0]    lo_rank;
    logic [POS_BITS-1:0]    hi_rank;
    logic [SAMPLE_BITS-1:0] lo_val;
    logic [SAMPLE_BITS-1:0] hi_val;
    logic [SAMPLE_BITS:0]   pair_sum;

    logic signed [SAMPLE_BITS-1:0] median_value_reg;
    logic signed [SAMPLE_BITS-1:0] median_value_next;
    logic                          median_valid_reg;
    logic                          median_valid_next;

    // Rank each valid slot among the valid slots; equal values break ties by
    // slot index so the ranks form a permutation.
    always_comb
    begin
        for (int i = 0; i < WINDOW; i++)
        begin
            slot_valid[i] = (CNT_BITS'(i) < fill_count);
            rank[i]       = '0;
            for (int j = 0; j < WINDOW; j++)
            begin
                if (j != i && CNT_BITS'(j) < fill_count &&
                    (($signed(window[j]) < $signed(window[i])) ||
                     (window[j] == window[i] && j < i)))
                begin
                    rank[i] = rank[i] + POS_BITS'(1);
                end
            end
        end
    end

    // Odd count: both ranks name the middle slot. Even count: the two middles.
    assign lo_rank = POS_BITS'((fill_count - CNT_BITS'(1)) >> 1);
    assign hi_rank = POS_BITS'(fill_count >> 1);

    always_comb
    begin
        lo_val = '0;
        hi_val = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            if (slot_valid[i] && rank[i] == lo_rank)
                lo_val = lo_val | window[i];
            if (slot_valid[i] && rank[i] == hi_rank)
                hi_val = hi_val | window[i];
        end
    end

    // Floor mean: sign-extend, add, drop the low bit.
    assign pair_sum = {lo_val[SAMPLE_BITS-1], lo_val} + {hi_val[SAMPLE_BITS-1], hi_val};

    always_comb
    begin
        median_value_next = median_value_reg;
        median_valid_next = median_valid_reg;
        if (stage.load)
        begin
            median_value_next = $signed(pair_sum[SAMPLE_BITS:1]);
            median_valid_next = 1'b1;
        end
        else if (stage.take)
        begin
            median_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            median_valid_reg <= 1'b0;
        else
            median_valid_reg <= median_valid_next;
    end

    always_ff @(posedge clk)
    begin
        median_value_reg <= median_value_next;
    end

    assign median_value = median_value_reg;
    assign median_valid = median_valid_reg;

endmodule
